// File: design/mev_pkg.sv
// Package for the 2x2 minimum-eigenvalue block.
// Holds the result field width and its saturation limit; no dependencies.
`default_nettype none

package mev_pkg;

  localparam int OUT_WIDTH = 23;
  localparam logic [OUT_WIDTH-1:0] OUT_MAX = {OUT_WIDTH{1'b1}};

endpackage

`default_nettype wire

// File: design/mev_in_if.sv
// Input channel of the minimum-eigenvalue block: valid, ready and one matrix item.
// Depends on nothing.
`default_nettype none

interface mev_in_if #(
  parameter int DATA_WIDTH = 24
) ();

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] m00;
  logic signed [DATA_WIDTH-1:0] m01;
  logic signed [DATA_WIDTH-1:0] m10;
  logic signed [DATA_WIDTH-1:0] m11;

  modport source (output valid, output m00, output m01, output m10, output m11, input ready);
  modport sink (input valid, input m00, input m01, input m10, input m11, output ready);

endinterface

`default_nettype wire

// File: design/mev_out_if.sv
// Output channel of the minimum-eigenvalue block: valid, ready and one result item.
// Depends on mev_pkg for the result width.
`default_nettype none

interface mev_out_if ();

  logic                            valid;
  logic                            ready;
  logic [mev_pkg::OUT_WIDTH-1:0]   min_root;
  logic                            roots_positive;

  modport source (output valid, output min_root, output roots_positive, input ready);
  modport sink (input valid, input min_root, input roots_positive, output ready);

endinterface

`default_nettype wire

// File: design/min_eigenvalue_2x2_top.sv
// Smaller eigenvalue of a 2x2 matrix given in signed fixed point. The block takes one matrix
// item per clock while the skid entry is empty, and returns one result item per matrix, in order.
// Three front stages form the trace, the squared difference of the diagonal, the off-diagonal
// product and the discriminant; a row of DATA_WIDTH + 1 cells then extracts the integer square
// root one bit per cell, and a final stage halves the difference of trace and root into an
// output register backed by one skid entry. The chain length of the square root sets the
// latency; throughput is one item per cycle while the skid entry is empty.
// Depends on mev_pkg, mev_in_if, mev_out_if, mev_front, mev_sqrt_cell and mev_back.
`default_nettype none

module min_eigenvalue_2x2_top #(
  parameter int DATA_WIDTH = 24
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mev_in_if.sink    in_i,
  mev_out_if.source out_o
);

  localparam int R  = DATA_WIDTH + 1;
  localparam int DW = 2 * DATA_WIDTH + 2;

  logic                         en;
  logic                         cv    [0:R];
  logic signed [DATA_WIDTH:0]   ct    [0:R];
  logic                         cpos  [0:R];
  logic [DW-1:0]                crem  [0:R];
  logic [R-1:0]                 croot [0:R];

  assign croot[0] = '0;

  mev_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .en_i    (en),
    .valid_o (cv[0]),
    .t_o     (ct[0]),
    .rem_o   (crem[0]),
    .pos_o   (cpos[0])
  );

  for (genvar i = 0; i < R; i++) begin : g_cell
    mev_sqrt_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .BIT       (R - 1 - i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cv[i]),
      .t_i     (ct[i]),
      .pos_i   (cpos[i]),
      .rem_i   (crem[i]),
      .root_i  (croot[i]),
      .valid_o (cv[i+1]),
      .t_o     (ct[i+1]),
      .pos_o   (cpos[i+1]),
      .rem_o   (crem[i+1]),
      .root_o  (croot[i+1])
    );
  end

  mev_back #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cv[R]),
    .t_i     (ct[R]),
    .pos_i   (cpos[R]),
    .root_i  (croot[R]),
    .en_o    (en),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// File: design/mev_front.sv
// Front end: trace, difference, the two products and the discriminant in three stages.
// Depends on mev_in_if.
`default_nettype none

module mev_front #(
  parameter int DATA_WIDTH = 24
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  mev_in_if.sink                          in_i,
  input  wire logic                       en_i,
  output logic                            valid_o,
  output logic signed [DATA_WIDTH:0]      t_o,
  output logic [2*DATA_WIDTH+1:0]         rem_o,
  output logic                            pos_o
);

  localparam int W = DATA_WIDTH;

  logic                   v0_q, v1_q, v2_q;
  logic signed [W:0]      t0_q, t1_q, t2_q;
  logic signed [W:0]      diff_q, diff_d;
  logic signed [2*W-1:0]  bc0_q, bc1_q;
  logic signed [2*W+1:0]  sq_q;
  logic [2*W+2:0]         disc_d;
  logic                   pos_d;
  logic [2*W+1:0]         rem_q, rem_d;
  logic                   pos_q;

  assign in_i.ready = en_i;

  always_comb begin
    diff_d = $signed({in_i.m00[W-1], in_i.m00}) - $signed({in_i.m11[W-1], in_i.m11});
    disc_d = {sq_q[2*W+1], sq_q} + {bc1_q[2*W-1], bc1_q, 2'b00};
    pos_d  = !disc_d[2*W+2] && (|disc_d);
    rem_d  = pos_d ? {1'b0, disc_d[2*W:0]} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= in_i.valid;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t0_q   <= $signed({in_i.m00[W-1], in_i.m00}) + $signed({in_i.m11[W-1], in_i.m11});
      diff_q <= diff_d;
      bc0_q  <= in_i.m01 * in_i.m10;
      t1_q   <= t0_q;
      sq_q   <= diff_q * diff_q;
      bc1_q  <= bc0_q;
      t2_q   <= t1_q;
      rem_q  <= rem_d;
      pos_q  <= pos_d;
    end
  end

  assign valid_o = v2_q;
  assign t_o     = t2_q;
  assign rem_o   = rem_q;
  assign pos_o   = pos_q;

endmodule

`default_nettype wire

// File: design/mev_sqrt_cell.sv
// One cell of the square-root chain: decides one root bit and passes the item on.
// Depends on nothing; instantiated in a row by the top level.
`default_nettype none

module mev_sqrt_cell #(
  parameter int DATA_WIDTH = 24,
  parameter int BIT        = 0
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic signed [DATA_WIDTH:0]   t_i,
  input  wire logic                         pos_i,
  input  wire logic [2*DATA_WIDTH+1:0]      rem_i,
  input  wire logic [DATA_WIDTH:0]          root_i,
  output logic                              valid_o,
  output logic signed [DATA_WIDTH:0]        t_o,
  output logic                              pos_o,
  output logic [2*DATA_WIDTH+1:0]           rem_o,
  output logic [DATA_WIDTH:0]               root_o
);

  localparam int RW = DATA_WIDTH + 1;
  localparam int DW = 2 * DATA_WIDTH + 2;

  logic          valid_q;
  logic [RW-1:0] root_q, root_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] trial;
  logic          fits;
  logic signed [DATA_WIDTH:0] t_q;
  logic          pos_q;

  // Growing the root by this bit adds 2^(BIT+1)*root + 2^(2*BIT) to its square.
  always_comb begin
    trial  = ({{(DW-RW){1'b0}}, root_i} << (BIT + 1)) | (DW'(1) << (2 * BIT));
    fits   = rem_i >= trial;
    rem_d  = fits ? rem_i - trial : rem_i;
    root_d = fits ? (root_i | (RW'(1) << BIT)) : root_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q <= root_d;
      rem_q  <= rem_d;
      t_q    <= t_i;
      pos_q  <= pos_i;
    end
  end

  assign valid_o = valid_q;
  assign t_o     = t_q;
  assign pos_o   = pos_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;

endmodule

`default_nettype wire

// File: design/mev_back.sv
// Back end: forms the halved smaller root with saturation and holds it in an
// output register with a skid entry. Depends on mev_pkg and mev_out_if.
`default_nettype none

module mev_back #(
  parameter int DATA_WIDTH = 24
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  input  wire logic signed [DATA_WIDTH:0] t_i,
  input  wire logic                       pos_i,
  input  wire logic [DATA_WIDTH:0]        root_i,
  output logic                            en_o,
  mev_out_if.source                       out_o
);

  import mev_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int EW = (W + 1 > OUT_WIDTH) ? W + 1 : OUT_WIDTH;

  logic [W+2:0]           l2;
  logic [W:0]             half;
  logic [EW-1:0]          half_ext;
  logic                   take;
  logic [OUT_WIDTH-1:0]   root_val;

  logic                   out_valid_q, out_valid_d;
  logic [OUT_WIDTH-1:0]   out_root_q, out_root_d;
  logic                   out_pos_q, out_pos_d;
  logic                   skid_valid_q, skid_valid_d;
  logic [OUT_WIDTH-1:0]   skid_root_q;
  logic                   skid_pos_q;
  logic                   push, load_out;

  always_comb begin
    l2       = {t_i[W], t_i[W], t_i} - {2'b00, root_i};
    half     = l2[W+1:1];
    half_ext = EW'(half);
    take     = pos_i && !l2[W+2] && (|half);
    if (!take) begin
      root_val = '0;
    end else if (half_ext > EW'(OUT_MAX)) begin
      root_val = OUT_MAX;
    end else begin
      root_val = half_ext[OUT_WIDTH-1:0];
    end
  end

  assign en_o     = !skid_valid_q;
  assign push     = valid_i && en_o;
  assign load_out = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_root_d   = out_root_q;
    out_pos_d    = out_pos_q;
    skid_valid_d = skid_valid_q;
    if (load_out) begin
      out_valid_d  = skid_valid_q || push;
      out_root_d   = skid_valid_q ? skid_root_q : root_val;
      out_pos_d    = skid_valid_q ? skid_pos_q : take;
      skid_valid_d = 1'b0;
    end else if (push) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_root_q <= out_root_d;
    out_pos_q  <= out_pos_d;
    if (!load_out && push) begin
      skid_root_q <= root_val;
      skid_pos_q  <= take;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.min_root       = out_root_q;
  assign out_o.roots_positive = out_pos_q;

  a_zero_when_not_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_pos_q |-> out_root_q == '0)
    else $error("result without flag carries a nonzero root");

  a_skid_behind_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds an item while the output register is empty");

  a_stalled_push_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && out_valid_q && !out_o.ready |=> skid_valid_q)
    else $error("item arriving at a stalled output was not kept");

endmodule

`default_nettype wire

// File: bench/tb_min_eigenvalue_2x2_top.sv
// Testbench for min_eigenvalue_2x2_top: directed and random matrices with random input gaps and
// output stalls, each result checked against a predicted smaller eigenvalue and flag.
// Depends on mev_pkg, mev_in_if, mev_out_if and the block under test.
module tb_min_eigenvalue_2x2_top;

  import mev_pkg::*;

  localparam int DW = 24;
  localparam int LATENCY = DW + 5;
  localparam int STALL_LIMIT = 1000;

  typedef struct {
    logic [OUT_WIDTH-1:0] min_root;
    logic                 roots_positive;
  } root_t;

  logic clk_i;
  logic rst_ni;

  mev_in_if #(.DATA_WIDTH(DW)) mat_if ();
  mev_out_if root_if ();

  min_eigenvalue_2x2_top #(.DATA_WIDTH(DW)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (mat_if),
    .out_o (root_if)
  );

  root_t pending_roots[$];
  int    error_count = 0;
  bit    gaps_on = 1'b1;
  int    idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic root_t predict_min_root(logic signed [DW-1:0] m00, logic signed [DW-1:0] m01,
                                             logic signed [DW-1:0] m10, logic signed [DW-1:0] m11);
    longint a, b, c, d, trace, disc, root, trial, half;
    int     k;
    root_t  r;
    a = m00;
    b = m01;
    c = m10;
    d = m11;
    r.min_root = '0;
    r.roots_positive = 1'b0;
    trace = a + d;
    disc = (a - d) * (a - d) + 4 * b * c;
    if (disc > 0) begin
      root = 0;
      for (k = 30; k >= 0; k--) begin
        trial = root | (longint'(1) << k);
        if (trial * trial <= disc) root = trial;
      end
      if (trace - root >= 2) begin
        half = (trace - root) >>> 1;
        if (half > longint'(OUT_MAX)) half = longint'(OUT_MAX);
        r.min_root = half[OUT_WIDTH-1:0];
        r.roots_positive = 1'b1;
      end
    end
    return r;
  endfunction

  // Results are checked before new items are recorded, so an item accepted at the same edge
  // can never be matched with a result.
  always @(posedge clk_i) begin
    root_t want;
    if (rst_ni) begin
      if (root_if.valid && root_if.ready) begin
        if (pending_roots.size() == 0) begin
          $error("unexpected result: min_root %0d roots_positive %0b",
                 root_if.min_root, root_if.roots_positive);
          error_count++;
        end else begin
          want = pending_roots.pop_front();
          if (root_if.min_root !== want.min_root) begin
            $error("min_root: expected %0d, actual %0d", want.min_root, root_if.min_root);
            error_count++;
          end
          if (root_if.roots_positive !== want.roots_positive) begin
            $error("roots_positive: expected %0b, actual %0b", want.roots_positive,
                   root_if.roots_positive);
            error_count++;
          end
        end
      end
      if (mat_if.valid && mat_if.ready)
        pending_roots.push_back(predict_min_root(mat_if.m00, mat_if.m01, mat_if.m10, mat_if.m11));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((mat_if.valid && mat_if.ready) || (root_if.valid && root_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    root_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        root_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        root_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_matrix(input logic signed [DW-1:0] m00, input logic signed [DW-1:0] m01,
                             input logic signed [DW-1:0] m10, input logic signed [DW-1:0] m11);
    mat_if.valid <= 1'b1;
    mat_if.m00 <= m00;
    mat_if.m01 <= m01;
    mat_if.m10 <= m10;
    mat_if.m11 <= m11;
    do @(posedge clk_i); while (!mat_if.ready);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      mat_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    mat_if.valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [DW-1:0] rand_mag();
    return DW'($urandom_range(0, 8388607) >> $urandom_range(0, 23));
  endfunction

  function automatic logic signed [DW-1:0] rand_signed();
    logic signed [DW-1:0] v;
    v = rand_mag();
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // Half of the items are symmetric or same-sign matrices, whose roots are real and often positive.
  task automatic send_random_matrix();
    logic signed [DW-1:0] a, b, c, d;
    case ($urandom_range(0, 9))
      0, 1: begin
        a = DW'($urandom());
        b = DW'($urandom());
        c = DW'($urandom());
        d = DW'($urandom());
      end
      2, 3, 4, 5, 6: begin
        a = rand_mag();
        d = rand_mag();
        b = rand_signed();
        if ($urandom_range(0, 1)) c = b;
        else c = (b < 0) ? -rand_mag() : rand_mag();
      end
      7: begin
        a = rand_signed();
        d = a ^ DW'($urandom_range(0, 3));
        b = DW'($urandom_range(0, 4) - 2);
        c = DW'($urandom_range(0, 4) - 2);
      end
      8: begin
        a = -rand_mag();
        d = rand_signed();
        b = rand_signed();
        c = rand_signed();
      end
      default: begin
        a = rand_signed();
        d = rand_signed();
        b = rand_mag();
        c = -rand_mag();
      end
    endcase
    send_matrix(a, b, c, d);
  endtask

  task automatic test_extreme_values();
    send_matrix(24'sd8388607, 24'sd8388607, 24'sd8388607, 24'sd8388607);
    send_matrix(-24'sd8388608, -24'sd8388608, -24'sd8388608, -24'sd8388608);
    send_matrix(24'sd8388607, 24'sd0, 24'sd0, -24'sd8388608);
    send_matrix(-24'sd8388608, 24'sd8388607, -24'sd8388608, 24'sd8388607);
    send_matrix(24'sd0, 24'sd0, 24'sd0, 24'sd0);
    send_matrix(24'sd8388607, 24'sd0, 24'sd0, 24'sd8388606);
    send_matrix(24'sd8388607, 24'sd1, 24'sd1, 24'sd8388607);
  endtask

  task automatic test_complex_roots();
    send_matrix(24'sd4096, 24'sd4096, -24'sd4096, 24'sd4096);
    send_matrix(24'sd4096, 24'sd8388607, -24'sd8388608, 24'sd4096);
  endtask

  task automatic test_repeated_roots();
    send_matrix(24'sd4096, 24'sd0, 24'sd0, 24'sd4096);
    send_matrix(24'sd8192, 24'sd4096, 24'sd0, 24'sd8192);
    send_matrix(24'sd12288, -24'sd4096, 24'sd4096, 24'sd4096);
  endtask

  task automatic test_nonpositive_roots();
    send_matrix(-24'sd4096, 24'sd0, 24'sd0, -24'sd8192);
    send_matrix(24'sd4096, 24'sd4096, 24'sd4096, 24'sd4096);
    send_matrix(24'sd3, 24'sd1, 24'sd0, 24'sd0);
    send_matrix(24'sd3, -24'sd1, 24'sd1, 24'sd0);
  endtask

  task automatic test_rounding();
    send_matrix(24'sd12288, 24'sd1, 24'sd1, 24'sd4096);
    send_matrix(24'sd40960, 24'sd1, 24'sd3, 24'sd4096);
    send_matrix(24'sd6, 24'sd1, 24'sd1, 24'sd1);
    send_matrix(24'sd8192, 24'sd0, -24'sd4096, 24'sd4096);
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_random_matrix();
  endtask

  task automatic test_back_to_back(input int count);
    gaps_on = 1'b0;
    repeat (count) send_random_matrix();
  endtask

  initial begin
    rst_ni <= 1'b0;
    mat_if.valid <= 1'b0;
    mat_if.m00 <= '0;
    mat_if.m01 <= '0;
    mat_if.m10 <= '0;
    mat_if.m11 <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extreme_values();
    test_complex_roots();
    test_repeated_roots();
    test_nonpositive_roots();
    test_rounding();
    wait_for_results();
    test_random_mix(1400);
    test_back_to_back(300);

    wait_for_results();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
design/mev_pkg.sv
design/mev_in_if.sv
design/mev_out_if.sv
design/mev_front.sv
design/mev_sqrt_cell.sv
design/mev_back.sv
design/min_eigenvalue_2x2_top.sv
bench/tb_min_eigenvalue_2x2_top.sv
